// ===== hw/rtl/rch_pkg.sv =====
// ----------------------------------------------------------------------------
// rch_pkg: shared types and constants for the range class histogram
// Holds class limits, field widths, request encoding and register indexes.
// ----------------------------------------------------------------------------
package rch_pkg;

  localparam int MAX_CLASSES  = 32;
  localparam int SLOT_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CADDR_W      = $clog2(MAX_CLASSES + 1);
  localparam int CLASS_SLOT_W = 5;
  localparam int BIN_W        = 6;
  localparam int DATA_W       = 32;
  localparam int WIDTH_W      = 31;
  localparam int EW_W         = 40;
  localparam int CFG_IDX_W    = 3;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST   = WIDTH_W'(1024);
  localparam logic [BIN_W-1:0]   CLASS_COUNT_RST = BIN_W'(32);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_MODE  = 3'd0,
    CFG_RANGE_LOW   = 3'd1,
    CFG_BIN_WIDTH   = 3'd2,
    CFG_CLASS_COUNT = 3'd3,
    CFG_REPORT_UNC  = 3'd4
  } cfg_idx_t;

  // One decoded request; val_a carries bound_low or the sample
  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
  } rch_req_t;

endpackage

// ===== hw/rtl/rch_front.sv =====
// ----------------------------------------------------------------------------
// rch_front: request intake
// Decodes the action, packs the operands and drops loads to absent slots.
// ----------------------------------------------------------------------------
module rch_front import rch_pkg::*; (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic [CLASS_SLOT_W-1:0] in_class_slot,
  input  logic [DATA_W-1:0]       in_bound_low,
  input  logic [DATA_W-1:0]       in_bound_high,
  input  logic [DATA_W-1:0]       in_sample,
  input  logic                    q_full,
  output logic                    q_push,
  output rch_req_t                q_req
);

  logic accept;
  logic slot_ok;
  op_t  op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign op       = op_t'(in_action);
  assign slot_ok  = (32'(in_class_slot) < 32'(MAX_CLASSES));

  always_comb begin
    q_req.op    = op;
    q_req.slot  = SLOT_W'(in_class_slot);
    q_req.val_b = in_bound_high;
    case (op)
      OP_SAMPLE: q_req.val_a = in_sample;
      default:   q_req.val_a = in_bound_low;
    endcase
  end

  // drop loads that address no table entry
  assign q_push = accept && !((op == OP_LOAD) && !slot_ok);

endmodule

// ===== hw/rtl/rch_queue.sv =====
// ----------------------------------------------------------------------------
// rch_queue: request queue
// Small FIFO between intake and execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module rch_queue import rch_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rch_req_t push_req,
  input  logic     pop,
  output rch_req_t head,
  output logic     empty,
  output logic     full
);

  rch_req_t            q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ===== hw/rtl/rch_back.sv =====
// ----------------------------------------------------------------------------
// rch_back: request execution
// Walks class bounds one per cycle, updates counts and streams dump records.
// ----------------------------------------------------------------------------
module rch_back import rch_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  rch_req_t             head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [BIN_W-1:0]     out_bin_index,
  output logic                 out_matched,
  output logic                 out_is_unclassed,
  output logic [DATA_W-1:0]    out_bin_count,
  output logic [DATA_W-1:0]    out_cumulative,
  output logic                 out_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_UPD  = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

  localparam logic [CADDR_W-1:0] UNC_ADDR = CADDR_W'(MAX_CLASSES);

  // configuration
  logic                class_mode_r;
  logic [DATA_W-1:0]   range_low_r;
  logic [WIDTH_W-1:0]  bin_width_r;
  logic [BIN_W-1:0]    class_count_r;
  logic                report_r;
  logic [BIN_W-1:0]    n_eff;
  logic [BIN_W-1:0]    n_last;

  // control
  state_t              state_r, state_nxt;
  logic [BIN_W-1:0]    idx_r, idx_nxt;
  logic signed [EW_W-1:0] eq_lo_r, eq_lo_nxt;
  logic [DATA_W-1:0]   smp_r, smp_nxt;
  logic                matched_r, matched_nxt;
  logic [CADDR_W-1:0]  caddr_r, caddr_nxt;
  logic [DATA_W-1:0]   cum_r, cum_nxt;

  // memories
  logic [DATA_W-1:0]   lows_mem  [MAX_CLASSES];
  logic [DATA_W-1:0]   highs_mem [MAX_CLASSES];
  logic [DATA_W-1:0]   tab_lo_q, tab_hi_q;
  logic [SLOT_W-1:0]   tab_raddr;
  logic                tab_we;
  logic [DATA_W-1:0]   cnt_mem [MAX_CLASSES + 1];
  logic [MAX_CLASSES:0] cnt_vld_r;
  logic [DATA_W-1:0]   cnt_q;
  logic                cnt_vq;
  logic                cnt_we;
  logic                clr;
  logic [DATA_W-1:0]   cnt_eff;
  logic [DATA_W-1:0]   cnt_inc;

  // search datapath
  logic signed [EW_W-1:0] width_x, lo_x, hi_x, s_x;
  logic                hit;
  logic [SLOT_W-1:0]   idx_slot;
  logic [DATA_W:0]     run_sum;
  logic [DATA_W-1:0]   run_sat;
  logic                rec_unc;

  // result register
  logic                out_free;
  logic                emit;
  logic                e_kind, e_matched, e_unc, e_last;
  logic [BIN_W-1:0]    e_index;
  logic [DATA_W-1:0]   e_count, e_cum;
  logic                out_valid_r;
  logic                out_kind_r, out_matched_r, out_unc_r, out_last_r;
  logic [BIN_W-1:0]    out_index_r;
  logic [DATA_W-1:0]   out_count_r, out_cum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_mode_r  <= 1'b0;
      range_low_r   <= '0;
      bin_width_r   <= BIN_WIDTH_RST;
      class_count_r <= CLASS_COUNT_RST;
      report_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLASS_MODE:  class_mode_r  <= cfg_wdata[0];
        CFG_RANGE_LOW:   range_low_r   <= cfg_wdata;
        CFG_BIN_WIDTH:   bin_width_r   <= cfg_wdata[WIDTH_W-1:0];
        CFG_CLASS_COUNT: class_count_r <= cfg_wdata[BIN_W-1:0];
        CFG_REPORT_UNC:  report_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (class_count_r == '0) begin
      n_eff = BIN_W'(1);
    end else if (class_count_r > BIN_W'(MAX_CLASSES)) begin
      n_eff = BIN_W'(MAX_CLASSES);
    end else begin
      n_eff = class_count_r;
    end
  end
  assign n_last = n_eff - 1'b1;

  assign idx_slot = idx_r[SLOT_W-1:0];
  assign width_x  = {{(EW_W - WIDTH_W){1'b0}}, bin_width_r};
  assign s_x      = {{(EW_W - DATA_W){smp_r[DATA_W-1]}}, smp_r};

  always_comb begin
    if (class_mode_r) begin
      lo_x = {{(EW_W - DATA_W){tab_lo_q[DATA_W-1]}}, tab_lo_q};
      hi_x = {{(EW_W - DATA_W){tab_hi_q[DATA_W-1]}}, tab_hi_q};
    end else begin
      lo_x = eq_lo_r;
      hi_x = eq_lo_r + width_x;
    end
  end
  assign hit = (lo_x <= s_x) && (s_x <= hi_x);

  assign cnt_eff = cnt_vq ? cnt_q : '0;
  assign cnt_inc = (cnt_eff == '1) ? cnt_eff : cnt_eff + 1'b1;
  assign run_sum = {1'b0, cum_r} + {1'b0, cnt_eff};
  assign run_sat = run_sum[DATA_W] ? '1 : run_sum[DATA_W-1:0];
  assign rec_unc = (caddr_r == UNC_ADDR);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    eq_lo_nxt   = eq_lo_r;
    smp_nxt     = smp_r;
    matched_nxt = matched_r;
    caddr_nxt   = caddr_r;
    cum_nxt     = cum_r;
    q_pop       = 1'b0;
    tab_we      = 1'b0;
    clr         = 1'b0;
    cnt_we      = 1'b0;
    emit        = 1'b0;
    e_kind      = 1'b0;
    e_index     = '0;
    e_matched   = 1'b0;
    e_unc       = 1'b0;
    e_count     = '0;
    e_cum       = '0;
    e_last      = 1'b0;
    tab_raddr   = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (head.op)
            OP_LOAD: begin
              tab_we = 1'b1;
            end
            OP_SAMPLE: begin
              smp_nxt   = head.val_a;
              idx_nxt   = '0;
              eq_lo_nxt = {{(EW_W - DATA_W){range_low_r[DATA_W-1]}}, range_low_r};
              state_nxt = S_LOOK;
            end
            OP_DUMP: begin
              caddr_nxt = '0;
              cum_nxt   = '0;
              state_nxt = S_DUMP;
            end
            OP_CLEAR: begin
              clr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        // prefetch the next table entry
        tab_raddr = (idx_slot == SLOT_W'(MAX_CLASSES - 1)) ? '0 : idx_slot + 1'b1;
        if (hit) begin
          matched_nxt = 1'b1;
          caddr_nxt   = CADDR_W'(idx_r);
          state_nxt   = S_UPD;
        end else if (idx_r == n_last) begin
          matched_nxt = 1'b0;
          caddr_nxt   = UNC_ADDR;
          state_nxt   = S_UPD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          eq_lo_nxt = eq_lo_r + width_x;
        end
      end
      S_UPD: begin
        if (out_free) begin
          emit      = 1'b1;
          e_index   = matched_r ? idx_r : n_eff;
          e_matched = matched_r;
          e_unc     = !matched_r && report_r;
          e_last    = 1'b1;
          cnt_we    = matched_r || report_r;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = 1'b1;
          e_unc   = rec_unc;
          e_index = rec_unc ? n_eff : BIN_W'(caddr_r);
          e_count = cnt_eff;
          e_cum   = rec_unc ? '0 : run_sat;
          e_last  = rec_unc || ((caddr_r == CADDR_W'(n_last)) && !report_r);
          cum_nxt = run_sat;
          if (e_last) begin
            state_nxt = S_IDLE;
          end else if (caddr_r == CADDR_W'(n_last)) begin
            caddr_nxt = UNC_ADDR;
          end else begin
            caddr_nxt = caddr_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    eq_lo_r   <= eq_lo_nxt;
    smp_r     <= smp_nxt;
    matched_r <= matched_nxt;
    caddr_r   <= caddr_nxt;
    cum_r     <= cum_nxt;
  end

  // bound table
  always_ff @(posedge clk) begin
    if (tab_we) begin
      lows_mem[head.slot]  <= head.val_a;
      highs_mem[head.slot] <= head.val_b;
    end
    tab_lo_q <= lows_mem[tab_raddr];
    tab_hi_q <= highs_mem[tab_raddr];
  end

  // count memory, read one address ahead of use
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[caddr_r] <= cnt_inc;
    end
    cnt_q  <= cnt_mem[caddr_nxt];
    cnt_vq <= cnt_vld_r[caddr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (clr) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[caddr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r    <= e_kind;
      out_index_r   <= e_index;
      out_matched_r <= e_matched;
      out_unc_r     <= e_unc;
      out_count_r   <= e_count;
      out_cum_r     <= e_cum;
      out_last_r    <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_bin_index    = out_index_r;
  assign out_matched      = out_matched_r;
  assign out_is_unclassed = out_unc_r;
  assign out_bin_count    = out_count_r;
  assign out_cumulative   = out_cum_r;
  assign out_last         = out_last_r;

  a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && out_free) |=>
      (state_r == S_IDLE && out_valid_r && !out_kind_r && out_last_r))
    else $error("sample result not issued on update");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (cnt_vld_r == '0))
    else $error("clear left counts marked valid");

  a_unc_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r && out_unc_r) |-> (out_cum_r == '0 && out_last_r))
    else $error("unclassified dump record malformed");

  a_cum_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && emit && !e_last) |=>
      (state_r == S_DUMP && cum_r >= $past(cum_r)))
    else $error("dump cumulative decreased");

endmodule

// ===== hw/rtl/range_class_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// range_class_histogram_unit: histogram of Q16.16 samples over class ranges
// Requests enter on the in_ channel (valid/stall), results leave on out_.
// A request is a bound load, a sample, a dump or a clear; it passes a
// four-deep request queue before execution, so in_stall rises only when
// that queue is full. Loads and clears give no result.
// The class count n in use is class_count clamped to 1..32.
// A sample passes a start step, a bound search that tests one class per
// cycle (first match, up to n), and an update of its count. It returns
// one result. A dump returns n records, plus the unclassified record
// when enabled, after a start step, one per cycle while out_stall is low.
// Results sit in an output register; while out_stall is high the record
// holds and execution waits, but requests still queue up to the depth.
// Reset zeroes all counts at once and restores register defaults; the
// bound table is undefined until loaded. Write the cfg_ registers only
// while the block is idle.
// ----------------------------------------------------------------------------
module range_class_histogram_unit import rch_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DATA_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_action,
  input  logic [CLASS_SLOT_W-1:0] in_class_slot,
  input  logic [DATA_W-1:0]       in_bound_low,
  input  logic [DATA_W-1:0]       in_bound_high,
  input  logic [DATA_W-1:0]       in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic [BIN_W-1:0]        out_bin_index,
  output logic                    out_matched,
  output logic                    out_is_unclassed,
  output logic [DATA_W-1:0]       out_bin_count,
  output logic [DATA_W-1:0]       out_cumulative,
  output logic                    out_last
);

  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  rch_req_t q_req;
  rch_req_t q_head;

  rch_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_class_slot (in_class_slot),
    .in_bound_low  (in_bound_low),
    .in_bound_high (in_bound_high),
    .in_sample     (in_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_req         (q_req)
  );

  rch_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rch_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_bin_index    (out_bin_index),
    .out_matched      (out_matched),
    .out_is_unclassed (out_is_unclassed),
    .out_bin_count    (out_bin_count),
    .out_cumulative   (out_cumulative),
    .out_last         (out_last)
  );

endmodule

// ===== verif/range_class_histogram_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_class_histogram_unit_test: self-checking bench for the class histogram
// Requests from a pending queue go through a clocked driver. A built-in
// histogram predictor computes every sample answer and dump record. A clocked
// monitor checks each result against the oldest prediction. Both sides idle
// at random. Settings change only between phases, once the block is idle.
// ----------------------------------------------------------------------------
module range_class_histogram_unit_test;
  import rch_pkg::*;

  localparam int  RANDOM_ITEMS = 370;
  localparam int  DRAIN_CYCLES = 100;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  IDLE_PCT     = 36;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  typedef struct {
    op_t                      action;
    logic [CLASS_SLOT_W-1:0]  slot;
    logic signed [DATA_W-1:0] bound_low;
    logic signed [DATA_W-1:0] bound_high;
    logic signed [DATA_W-1:0] sample;
  } hist_req_t;

  typedef struct {
    logic              kind;
    logic [BIN_W-1:0]  bin_index;
    logic              matched;
    logic              is_unclassed;
    logic [DATA_W-1:0] bin_count;
    logic [DATA_W-1:0] cumulative;
    logic              last;
  } hist_res_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [DATA_W-1:0]       cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_action = '0;
  logic [CLASS_SLOT_W-1:0] in_class_slot = '0;
  logic [DATA_W-1:0]       in_bound_low = '0;
  logic [DATA_W-1:0]       in_bound_high = '0;
  logic [DATA_W-1:0]       in_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_kind;
  logic [BIN_W-1:0]        out_bin_index;
  logic                    out_matched;
  logic                    out_is_unclassed;
  logic [DATA_W-1:0]       out_bin_count;
  logic [DATA_W-1:0]       out_cumulative;
  logic                    out_last;

  range_class_histogram_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_class_slot    (in_class_slot),
    .in_bound_low     (in_bound_low),
    .in_bound_high    (in_bound_high),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_bin_index    (out_bin_index),
    .out_matched      (out_matched),
    .out_is_unclassed (out_is_unclassed),
    .out_bin_count    (out_bin_count),
    .out_cumulative   (out_cumulative),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the registers, bound table and counts
  logic                     cfg_mode = 1'b0;
  logic signed [DATA_W-1:0] cfg_range_low = '0;
  logic [WIDTH_W-1:0]       cfg_bin_width = BIN_WIDTH_RST;
  logic [BIN_W-1:0]         cfg_class_count = CLASS_COUNT_RST;
  logic                     cfg_report_unc = 1'b0;
  int                       class_lo_tab [MAX_CLASSES];
  int                       class_hi_tab [MAX_CLASSES];
  logic [DATA_W-1:0]        tally [MAX_CLASSES+1];

  // Bounds as queued, so samples can be aimed at classes before acceptance
  int plan_lo [MAX_CLASSES];
  int plan_hi [MAX_CLASSES];

  hist_req_t pending_reqs[$];
  hist_res_t expected_results[$];
  hist_req_t driven_req;
  hist_res_t oldest_result;

  bit calm = 1'b0;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int n_samples = 0;
  int n_dumps = 0;
  int n_loads = 0;
  int n_clears = 0;
  int n_settings = 1;

  initial begin
    for (int i = 0; i <= MAX_CLASSES; i++) tally[i] = '0;
  end

  function automatic int active_classes();
    int n;
    n = cfg_class_count;
    if (n < 1) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = a + b;
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  task automatic predict_histogram(input hist_req_t req);
    int n;
    int i;
    int hit;
    longint s;
    longint lo;
    longint hi;
    logic [DATA_W-1:0] run_sum;
    hist_res_t res;
    n = active_classes();
    res = '{default: '0};
    case (req.action)
      OP_LOAD: begin
        if (int'(req.slot) < MAX_CLASSES) begin
          class_lo_tab[req.slot] = req.bound_low;
          class_hi_tab[req.slot] = req.bound_high;
        end
      end
      OP_SAMPLE: begin
        s = longint'(req.sample);
        hit = -1;
        for (i = 0; i < n && hit < 0; i++) begin
          if (cfg_mode) begin
            lo = class_lo_tab[i];
            hi = class_hi_tab[i];
          end else begin
            lo = longint'(cfg_range_low) + longint'(i) * longint'(cfg_bin_width);
            hi = longint'(cfg_range_low) + longint'(i + 1) * longint'(cfg_bin_width);
          end
          if (lo <= s && s <= hi) hit = i;
        end
        res.kind = KIND_SAMPLE;
        res.last = 1'b1;
        if (hit >= 0) begin
          res.bin_index = BIN_W'(hit);
          res.matched = 1'b1;
          tally[hit] = sat_add(tally[hit], DATA_W'(1));
        end else begin
          res.bin_index = BIN_W'(n);
          if (cfg_report_unc) begin
            res.is_unclassed = 1'b1;
            tally[MAX_CLASSES] = sat_add(tally[MAX_CLASSES], DATA_W'(1));
          end
        end
        expected_results.push_back(res);
      end
      OP_DUMP: begin
        run_sum = '0;
        for (i = 0; i < n; i++) begin
          run_sum = sat_add(run_sum, tally[i]);
          res.kind = KIND_DUMP;
          res.bin_index = BIN_W'(i);
          res.bin_count = tally[i];
          res.cumulative = run_sum;
          res.last = (i == n - 1) && !cfg_report_unc;
          expected_results.push_back(res);
        end
        if (cfg_report_unc) begin
          res.kind = KIND_DUMP;
          res.bin_index = BIN_W'(n);
          res.is_unclassed = 1'b1;
          res.bin_count = tally[MAX_CLASSES];
          res.cumulative = '0;
          res.last = 1'b1;
          expected_results.push_back(res);
        end
      end
      OP_CLEAR: begin
        for (i = 0; i <= MAX_CLASSES; i++) tally[i] = '0;
      end
    endcase
  endtask

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: hold a stalled request, advance when the slot frees up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_histogram(driven_req);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
          driven_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_action <= driven_req.action;
          in_class_slot <= driven_req.slot;
          in_bound_low <= driven_req.bound_low;
          in_bound_high <= driven_req.bound_high;
          in_sample <= driven_req.sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: bin_index %0d", out_bin_index);
          fail_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          compare_field("kind", DATA_W'(oldest_result.kind), DATA_W'(out_kind));
          compare_field("bin_index", DATA_W'(oldest_result.bin_index),
                        DATA_W'(out_bin_index));
          compare_field("matched", DATA_W'(oldest_result.matched), DATA_W'(out_matched));
          compare_field("is_unclassed", DATA_W'(oldest_result.is_unclassed),
                        DATA_W'(out_is_unclassed));
          compare_field("bin_count", oldest_result.bin_count, out_bin_count);
          compare_field("cumulative", oldest_result.cumulative, out_cumulative);
          compare_field("last", DATA_W'(oldest_result.last), DATA_W'(out_last));
        end
      end
      out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic queue_request(input hist_req_t req);
    pending_reqs.push_back(req);
    queued_cnt++;
    case (req.action)
      OP_LOAD: begin
        n_loads++;
        plan_lo[req.slot] = req.bound_low;
        plan_hi[req.slot] = req.bound_high;
      end
      OP_SAMPLE: n_samples++;
      OP_DUMP:   n_dumps++;
      OP_CLEAR:  n_clears++;
    endcase
  endtask

  task automatic send_load(input logic [CLASS_SLOT_W-1:0] slot, input logic [DATA_W-1:0] lo,
                           input logic [DATA_W-1:0] hi);
    hist_req_t req;
    req.action = OP_LOAD;
    req.slot = slot;
    req.bound_low = lo;
    req.bound_high = hi;
    req.sample = $urandom;
    queue_request(req);
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] smp);
    hist_req_t req;
    req.action = OP_SAMPLE;
    req.slot = CLASS_SLOT_W'($urandom);
    req.bound_low = $urandom;
    req.bound_high = $urandom;
    req.sample = smp;
    queue_request(req);
  endtask

  task automatic send_op(input op_t op);
    hist_req_t req;
    req.action = op;
    req.slot = CLASS_SLOT_W'($urandom);
    req.bound_low = $urandom;
    req.bound_high = $urandom;
    req.sample = $urandom;
    queue_request(req);
  endtask

  // Mostly ordinary classes of varied size, some inverted, a few full-range
  task automatic send_random_bounds(input logic [CLASS_SLOT_W-1:0] slot);
    int pick;
    int lo_i;
    longint hi_l;
    pick = $urandom_range(99, 0);
    lo_i = $signed($urandom) >>> $urandom_range(31, 0);
    if (pick < 5) begin
      lo_i = 32'h8000_0000;
      hi_l = 64'sd2147483647;
    end else if (pick < 20) begin
      hi_l = longint'(lo_i) - 1 - longint'($urandom_range(1000, 0));
      if (hi_l < -64'sd2147483648) hi_l = lo_i;
    end else begin
      hi_l = longint'(lo_i) + longint'($urandom >> $urandom_range(31, 0));
      if (hi_l > 64'sd2147483647) hi_l = 64'sd2147483647;
    end
    send_load(slot, lo_i, hi_l[DATA_W-1:0]);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CLASS_MODE:  cfg_mode = value[0];
      CFG_RANGE_LOW:   cfg_range_low = value;
      CFG_BIN_WIDTH:   cfg_bin_width = value[WIDTH_W-1:0];
      CFG_CLASS_COUNT: cfg_class_count = value[BIN_W-1:0];
      CFG_REPORT_UNC:  cfg_report_unc = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic mode, input logic [DATA_W-1:0] rlow,
                                input logic [WIDTH_W-1:0] width, input logic [BIN_W-1:0] count,
                                input logic unc);
    write_reg(CFG_CLASS_MODE, DATA_W'(mode));
    write_reg(CFG_RANGE_LOW, rlow);
    write_reg(CFG_BIN_WIDTH, DATA_W'(width));
    write_reg(CFG_CLASS_COUNT, DATA_W'(count));
    write_reg(CFG_REPORT_UNC, DATA_W'(unc));
    n_settings++;
  endtask

  // Wait for every request and result, then let loads or clears finish
  task automatic wait_quiet();
    while (accepted_cnt != queued_cnt || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic               mode_v;
    logic               unc_v;
    logic [DATA_W-1:0]  rl_v;
    logic [WIDTH_W-1:0] w_v;
    logic [BIN_W-1:0]   cc_v;
    int                 n;
    int                 k;
    int                 pick;
    int                 cls;
    int                 phase;
    int                 random_base;
    longint             grid_pt;
    longint             lo_l;
    longint             hi_l;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 32 bins of 1024 from zero, shared edges go low
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0400);
    send_sample(32'h0000_0401);
    send_sample(32'h0000_8000);
    send_sample(32'h0000_8001);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_op(OP_DUMP);
    wait_quiet();

    // Oversized class count clamps; upper bins run past the 32-bit range
    apply_settings(1'b0, 32'h7FFF_0000, 31'h7FFF_FFFF, 6'd63, 1'b1);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFE_FFFF);
    send_sample(32'h8000_0000);
    send_op(OP_DUMP);
    wait_quiet();

    // Table: inverted class, overlapping classes, first match wins, clear
    apply_settings(1'b1, 32'h0, 31'd1024, 6'd3, 1'b1);
    send_load(5'd0, 32'h0000_0064, 32'hFFFF_FF9C);
    send_load(5'd1, 32'h8000_0000, 32'h0000_0000);
    send_load(5'd2, 32'hFFFF_FFFB, 32'h7FFF_FFFF);
    send_load(5'd31, 32'h0, 32'h0);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0032);
    send_sample(32'h0000_0064);
    send_op(OP_CLEAR);
    send_sample(32'h8000_0000);
    send_op(OP_DUMP);
    wait_quiet();

    // Zero class count acts as one class; miss with no unclassified bin
    apply_settings(1'b1, 32'h0, 31'd1024, 6'd0, 1'b0);
    send_sample(32'h0000_0000);
    send_op(OP_DUMP);
    wait_quiet();

    random_base = queued_cnt;
    // Fill the whole table so a search never reads an unloaded slot
    for (k = 0; k < MAX_CLASSES; k++) send_random_bounds(CLASS_SLOT_W'(k));

    phase = 0;
    while (queued_cnt - random_base < RANDOM_ITEMS) begin
      wait_quiet();
      calm = (phase == 3);
      mode_v = 1'($urandom_range(1, 0));
      case ($urandom_range(4, 0))
        0: rl_v = 32'h0;
        1: rl_v = 32'h8000_0000;
        2: rl_v = 32'h7FFF_FFFF;
        default: rl_v = $signed($urandom) >>> $urandom_range(31, 0);
      endcase
      case ($urandom_range(4, 0))
        0: w_v = '0;
        1: w_v = 31'd1;
        2: w_v = 31'h7FFF_FFFF;
        default: w_v = WIDTH_W'($urandom >> $urandom_range(31, 1));
      endcase
      case ($urandom_range(9, 0))
        0: cc_v = 6'd1;
        1: cc_v = 6'd32;
        2: cc_v = BIN_W'($urandom_range(63, 33));
        3: cc_v = 6'd0;
        default: cc_v = BIN_W'($urandom_range(32, 1));
      endcase
      unc_v = 1'($urandom_range(1, 0));
      apply_settings(mode_v, rl_v, w_v, cc_v, unc_v);
      n = active_classes();

      repeat ($urandom_range(45, 25)) begin
        pick = $urandom_range(99, 0);
        if (pick < 62) begin
          pick = $urandom_range(99, 0);
          if (!cfg_mode) begin
            // Aim at bin edges and interiors, with some misses outside
            k = $urandom_range(n + 1, 0);
            grid_pt = longint'(cfg_range_low) + longint'(k) * longint'(cfg_bin_width);
            if (pick < 30) ;
            else if (pick < 45) grid_pt += $urandom_range(1, 0) ? 1 : -1;
            else if (pick < 80) grid_pt += longint'($urandom_range(cfg_bin_width, 0));
            else if (pick < 93) grid_pt = longint'($signed($urandom));
            else grid_pt = $urandom_range(1, 0) ? 64'sd2147483647 : -64'sd2147483648;
          end else begin
            cls = $urandom_range(n - 1, 0);
            lo_l = plan_lo[cls];
            hi_l = plan_hi[cls];
            if (pick >= 85 || lo_l > hi_l) grid_pt = longint'($signed($urandom));
            else if (pick < 25) grid_pt = lo_l;
            else if (pick < 50) grid_pt = hi_l;
            else grid_pt = lo_l + longint'($urandom) % (hi_l - lo_l + 1);
          end
          send_sample(grid_pt[DATA_W-1:0]);
        end else if (pick < 74) begin
          send_op(OP_DUMP);
        end else if (pick < 92) begin
          send_random_bounds(CLASS_SLOT_W'($urandom));
        end else begin
          send_op(OP_CLEAR);
        end
      end
      send_op(OP_DUMP);
      phase++;
    end
    wait_quiet();
    calm = 1'b0;

    $display("Covered %0d requests: %0d samples, %0d dumps, %0d loads, %0d clears",
             queued_cnt, n_samples, n_dumps, n_loads, n_clears);
    $display("Checked %0d results across %0d register settings, %0d mismatches",
             results_seen, n_settings, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
